/* rtl/core/lfr_pkg.sv */
// Shared constants, codes and state type of the linked FIFO with removal.
`default_nettype none

package lfr_pkg;

	// Default sizing
	localparam int unsigned SLOTS_DEF    = 64;
	localparam int unsigned TAG_BITS_DEF = 16;

	// Fixed field widths on the stream ports
	localparam int unsigned OP_W       = 2;
	localparam int unsigned TAG_IN_W   = 16;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned HANDLE_W   = 6;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned SLOT_OUT_W = 6;
	localparam int unsigned TAG_OUT_W  = 16;

	// Packed stream words, padded to whole bytes
	localparam int unsigned IN_FIELDS_W  = TAG_IN_W + TIME_W + HANDLE_W;
	localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned IN_USER_W    = OP_W;
	localparam int unsigned OUT_FIELDS_W = SLOT_OUT_W + TAG_OUT_W + TIME_W;
	localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_USER_W   = STATUS_W;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} lfr_op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_BAD   = 2'd3
	} lfr_status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FIX
	} lfr_state_t;

endpackage

`default_nettype wire

/* rtl/core/lfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfr_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/linked_fifo_with_removal.sv */
// Top level: doubly linked queue over a slot pool with a free list, in RAM.
// Insert, peek and every error load the result in the read state; pop and
// remove load it in the fix state, after the read state. The result waits
// while the output holds. Requests are taken only in the idle state, so one
// is finished before the next, in steps set by the single next-link write port.
// Reset (asynchronous, active low) clears head, tail, count, free head and
// the fresh-slot counter; the memories are not cleared and need no sweep.
`default_nettype none

module linked_fifo_with_removal #(
	parameter int unsigned SLOTS    = lfr_pkg::SLOTS_DEF,
	parameter int unsigned TAG_BITS = lfr_pkg::TAG_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] entry_tag, [31:16] entry_time, [37:32] handle, [39:38] zero
	input  wire logic [lfr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [1:0] operation
	input  wire logic [lfr_pkg::IN_USER_W-1:0]   s_axis_tuser,
	// result stream
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [5:0] slot_out, [21:6] tag_out, [37:22] time_out, [39:38] zero
	output logic      [lfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// [1:0] status
	output logic      [lfr_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	import lfr_pkg::*;

	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
	localparam int unsigned PAY_W  = 1 + TAG_BITS + TIME_W;

	// Control registers
	lfr_state_t        state_q, state_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [SLOT_W-1:0] tail_q, tail_d;
	logic [SLOT_W-1:0] free_head_q, free_head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  fresh_q, fresh_d;
	logic              out_valid_q;

	// Per-request registers
	lfr_op_t           op_q;
	lfr_status_t       stat_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] nxt_q;
	logic [SLOT_W-1:0] prv_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [TIME_W-1:0] time_q;

	// Output registers
	logic [STATUS_W-1:0]   out_stat_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [TAG_OUT_W-1:0]  out_tag_q;
	logic [TIME_W-1:0]     out_time_q;

	// Request fields
	lfr_op_t           in_op;
	logic [TAG_IN_W-1:0] in_tag;
	logic [TIME_W-1:0] in_time;
	logic [HANDLE_W-1:0] in_handle;
	logic [SLOT_W-1:0] in_hidx;
	logic              accept;
	logic              fire;

	// Memory ports
	logic              mem_re;
	logic [SLOT_W-1:0] mem_raddr;
	logic              nx_we, pv_we, py_we;
	logic [SLOT_W-1:0] nx_waddr, pv_waddr, py_waddr;
	logic [SLOT_W-1:0] nx_wdata, pv_wdata;
	logic [PAY_W-1:0]  py_wdata;
	logic [SLOT_W-1:0] nx_rdata, pv_rdata;
	logic [PAY_W-1:0]  py_rdata;

	// Decoded read data and next-register values
	logic              rd_live;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TIME_W-1:0] rd_time;
	logic              slot_fresh_seen;
	logic              cap_item;
	lfr_status_t       cap_stat;
	logic [SLOT_W-1:0] cap_slot;
	logic              cap_hold;
	logic              out_load;
	lfr_status_t       res_stat;
	logic [SLOT_W-1:0] res_slot;
	logic [TAG_BITS-1:0] res_tag;
	logic [TIME_W-1:0] res_time;

	assign in_op     = lfr_op_t'(s_axis_tuser[OP_W-1:0]);
	assign in_tag    = s_axis_tdata[TAG_IN_W-1:0];
	assign in_time   = s_axis_tdata[TAG_IN_W +: TIME_W];
	assign in_handle = s_axis_tdata[TAG_IN_W + TIME_W +: HANDLE_W];
	assign in_hidx   = SLOT_W'(in_handle);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fire          = !out_valid_q || m_axis_tready;

	// Slots below the fresh counter have been written at least once
	assign slot_fresh_seen = (CNT_W'(slot_q) < fresh_q);
	assign rd_live = py_rdata[PAY_W-1] && slot_fresh_seen;
	assign rd_tag  = py_rdata[TIME_W +: TAG_BITS];
	assign rd_time = py_rdata[TIME_W-1:0];

	// Sequencer: next state, memory accesses and result
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		free_head_d = free_head_q;
		count_d     = count_q;
		fresh_d     = fresh_q;
		mem_re      = 1'b0;
		mem_raddr   = free_head_q;
		nx_we       = 1'b0;
		nx_waddr    = tail_q;
		nx_wdata    = free_head_q;
		pv_we       = 1'b0;
		pv_waddr    = free_head_q;
		pv_wdata    = tail_q;
		py_we       = 1'b0;
		py_waddr    = free_head_q;
		py_wdata    = {1'b1, TAG_BITS'(in_tag), in_time};
		cap_item    = 1'b0;
		cap_stat    = STAT_OK;
		cap_slot    = free_head_q;
		cap_hold    = 1'b0;
		out_load    = 1'b0;
		res_stat    = STAT_OK;
		res_slot    = '0;
		res_tag     = '0;
		res_time    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cap_item = 1'b1;
					mem_re   = 1'b1;
					state_d  = S_READ;
					unique case (in_op)
						OP_INSERT: begin
							cap_slot  = free_head_q;
							mem_raddr = free_head_q;
							if (count_q == CNT_W'(SLOTS)) begin
								cap_stat = STAT_FULL;
							end else begin
								// store payload, link behind the tail
								py_we    = 1'b1;
								pv_we    = 1'b1;
								pv_wdata = (count_q == '0) ? '0 : tail_q;
								nx_we    = (count_q != '0);
							end
						end
						OP_POP, OP_PEEK: begin
							cap_slot  = head_q;
							mem_raddr = head_q;
							cap_stat  = (count_q == '0) ? STAT_EMPTY : STAT_OK;
						end
						OP_REMOVE: begin
							cap_slot  = in_hidx;
							mem_raddr = in_hidx;
							cap_stat  = (32'(in_handle) < SLOTS) ? STAT_OK : STAT_BAD;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (stat_q != STAT_OK || (op_q == OP_REMOVE && !rd_live)) begin
					// report the error, state untouched
					if (fire) begin
						out_load = 1'b1;
						res_stat = (stat_q == STAT_OK) ? STAT_BAD : stat_q;
						state_d  = S_IDLE;
					end
				end else begin
					unique case (op_q)
						OP_INSERT: begin
							if (fire) begin
								// terminate the new tail, advance the free list
								nx_we    = 1'b1;
								nx_waddr = slot_q;
								nx_wdata = '0;
								if (slot_fresh_seen) begin
									free_head_d = nx_rdata;
								end else begin
									free_head_d = (slot_q == SLOT_W'(SLOTS - 1)) ? '0 :
										slot_q + SLOT_W'(1);
									fresh_d = fresh_q + CNT_W'(1);
								end
								if (count_q == '0) begin
									head_d = slot_q;
								end
								tail_d   = slot_q;
								count_d  = count_q + CNT_W'(1);
								out_load = 1'b1;
								res_slot = slot_q;
								state_d  = S_IDLE;
							end
						end
						OP_PEEK: begin
							if (fire) begin
								out_load = 1'b1;
								res_time = rd_time;
								state_d  = S_IDLE;
							end
						end
						OP_POP, OP_REMOVE: begin
							// bridge the neighbors and mark the slot free
							cap_hold = 1'b1;
							nx_we    = (slot_q != head_q);
							nx_waddr = pv_rdata;
							nx_wdata = nx_rdata;
							pv_we    = (slot_q != tail_q);
							pv_waddr = nx_rdata;
							pv_wdata = pv_rdata;
							py_we    = 1'b1;
							py_waddr = slot_q;
							py_wdata = '0;
							state_d  = S_FIX;
						end
						default: ;
					endcase
				end
			end
			S_FIX: begin
				if (fire) begin
					// push the slot on the free list, move head and tail
					nx_we       = 1'b1;
					nx_waddr    = slot_q;
					nx_wdata    = free_head_q;
					free_head_d = slot_q;
					if (slot_q == head_q) begin
						head_d = nxt_q;
					end
					if (slot_q == tail_q) begin
						tail_d = prv_q;
					end
					count_d  = count_q - CNT_W'(1);
					out_load = 1'b1;
					res_slot = slot_q;
					res_tag  = tag_q;
					res_time = time_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			free_head_q <= free_head_d;
			count_q     <= count_d;
			fresh_q     <= fresh_d;
		end
	end

	// Request fields held while the request is worked
	always_ff @(posedge clk) begin
		if (cap_item) begin
			op_q   <= in_op;
			stat_q <= cap_stat;
			slot_q <= cap_slot;
		end
		if (cap_hold) begin
			nxt_q  <= nx_rdata;
			prv_q  <= pv_rdata;
			tag_q  <= rd_tag;
			time_q <= rd_time;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stat_q <= res_stat;
			out_slot_q <= SLOT_OUT_W'(res_slot);
			out_tag_q  <= TAG_OUT_W'(res_tag);
			out_time_q <= res_time;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_time_q, out_tag_q, out_slot_q});

	// Next links
	lfr_ram #(
		.WIDTH  (SLOT_W),
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W)
	) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (nx_rdata)
	);

	// Previous links
	lfr_ram #(
		.WIDTH  (SLOT_W),
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W)
	) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (pv_rdata)
	);

	// Live flag, tag and time
	lfr_ram #(
		.WIDTH  (PAY_W),
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W)
	) u_pay_ram (
		.clk   (clk),
		.we    (py_we),
		.waddr (py_waddr),
		.wdata (py_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (py_rdata)
	);

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("live count beyond pool size");

	a_count_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("more live slots than slots ever handed out");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_head_q) < SLOTS)
		else $error("free list head outside pool");

	a_insert_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && fire && op_q == OP_INSERT && stat_q == STAT_OK)
		|=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the queue");

	a_unlink_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIX && fire) |=> count_q == CNT_W'($past(count_q) - CNT_W'(1)))
		else $error("unlink did not shrink the queue");

endmodule

`default_nettype wire
